// File: rtl/obp_pkg.sv
// Shared types and constants for the offset bit packer.
// Used by the front, back and top modules; depends on nothing.
package obp_pkg;

    localparam int VALUE_WIDTH_DEF = 32;   // default packing word width
    localparam int QUEUE_DEPTH     = 2;    // entries between front and back
    localparam int NB_W            = 7;    // holds a field width of 0..64
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    localparam logic [31:0] MAGIC_WORD = 32'h4249_4E21;  // "BIN!"
    localparam int          MAGIC_BITS = 32;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] min_value;
        logic [CFG_DATA_W-1:0] max_value;
        logic [CFG_DATA_W-1:0] value_count;
    } t_cfg;

    typedef struct packed {
        logic            header;   // item opens a run: header goes first
        logic            last;     // item closes a run: pad to byte
        logic [NB_W-1:0] nbits;    // packed field width of this item
    } t_item_ctl;

endpackage

// File: rtl/obp_fifo.sv
// Small register queue between the front and back parts of the packer.
// Generic width and depth; no package dependencies.
module obp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/obp_front.sv
// Front part of the packer: takes input beats, works out field width and
// offset, tracks run boundaries. Depends on obp_pkg.
module obp_front
    import obp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [31:0]            i_value,
    input  logic                   i_last,
    input  t_cfg                   i_cfg,
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output t_item_ctl              o_q_ctl,
    output logic [VALUE_WIDTH-1:0] o_q_offset
);
    logic                   r_hdr_pending;
    logic [VALUE_WIDTH-1:0] lo_x, hi_x, val_x, span, diff;
    logic [VALUE_WIDTH:0]   fld_mask;
    logic [NB_W-1:0]        nbits;

    assign lo_x  = VALUE_WIDTH'($signed(i_cfg.min_value));
    assign hi_x  = VALUE_WIDTH'($signed(i_cfg.max_value));
    assign val_x = VALUE_WIDTH'($signed(i_value));
    assign span  = hi_x - lo_x;
    assign diff  = val_x - lo_x;

    // bit length of the span
    always_comb begin
        nbits = '0;
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            if (span[i]) begin
                nbits = NB_W'(i + 1);
            end
        end
    end

    assign fld_mask = ((VALUE_WIDTH+1)'(1) << nbits) - (VALUE_WIDTH+1)'(1);

    assign o_in_ready     = !i_q_full;
    assign o_q_push       = i_in_valid && !i_q_full;
    assign o_q_ctl.header = r_hdr_pending;
    assign o_q_ctl.last   = i_last;
    assign o_q_ctl.nbits  = nbits;
    assign o_q_offset     = diff & fld_mask[VALUE_WIDTH-1:0];

    // a new header goes out on the beat after a run closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pending <= 1'b1;
        end else if (o_q_push) begin
            r_hdr_pending <= i_last;
        end
    end

endmodule

// File: rtl/obp_back.sv
// Back part of the packer: loads header and offset fields into a bit
// accumulator and sends one byte per cycle while the receiver is ready. Depends on obp_pkg.
module obp_back
    import obp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_q_valid,
    input  t_item_ctl              i_q_ctl,
    input  logic [VALUE_WIDTH-1:0] i_q_offset,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_byte_out,
    output logic                   o_end_of_run
);
    localparam int CW = ((VALUE_WIDTH > MAGIC_BITS) ? VALUE_WIDTH : MAGIC_BITS) + 8;
    localparam int AW = CW + 8;
    localparam int CNT_W = $clog2(AW + 1);
    localparam logic [2:0] VW_RES = 3'(VALUE_WIDTH % 8);

    typedef enum logic [4:0] {
        S_MAGIC = 5'b00001,
        S_MIN   = 5'b00010,
        S_MAX   = 5'b00100,
        S_CNT   = 5'b01000,
        S_DATA  = 5'b10000
    } t_step;

    logic [AW-1:0]    r_acc, n_acc, acc_sh;
    logic [CNT_W-1:0] r_cnt, n_cnt, cnt_after, chunk_n, shamt;
    t_step            r_step, n_step, step_cur;
    logic             r_drain, n_drain;
    logic             r_out_valid;
    logic [7:0]       r_byte;
    logic             r_end;

    logic             slot, emit, load, fin, data_byte, end_flag;
    logic [2:0]       res, res_cnt, pad;
    logic [NB_W:0]    sum_d, sum_c;
    logic [CW-1:0]    chunk;
    logic [VALUE_WIDTH-1:0] min_x, max_x, count_x;

    assign min_x   = VALUE_WIDTH'($signed(i_cfg.min_value));
    assign max_x   = VALUE_WIDTH'($signed(i_cfg.max_value));
    assign count_x = VALUE_WIDTH'(i_cfg.value_count);

    assign slot      = !r_out_valid || i_out_ready;
    assign emit      = (r_cnt >= CNT_W'(8)) && slot;
    assign cnt_after = emit ? r_cnt - CNT_W'(8) : r_cnt;
    assign load      = i_q_valid && (cnt_after < CNT_W'(8));
    assign step_cur  = i_q_ctl.header ? r_step : S_DATA;
    assign end_flag  = r_drain && (cnt_after < CNT_W'(8));

    // residual bits before the data field, now and after the count field
    assign res     = cnt_after[2:0];
    assign res_cnt = res + VW_RES;
    assign sum_d   = {1'b0, i_q_ctl.nbits} + (NB_W+1)'(res);
    assign sum_c   = {1'b0, i_q_ctl.nbits} + (NB_W+1)'(res_cnt);
    assign pad     = i_q_ctl.last ? 3'd0 - sum_d[2:0] : 3'd0;
    // does the data field complete a byte once the count field has drained
    assign data_byte = i_q_ctl.last ? (sum_c != '0) : (sum_c >= (NB_W+1)'(8));

    always_comb begin
        chunk   = '0;
        chunk_n = '0;
        fin     = 1'b0;
        n_step  = r_step;
        case (step_cur)
            S_MAGIC: begin
                chunk   = CW'(MAGIC_WORD);
                chunk_n = CNT_W'(MAGIC_BITS);
                n_step  = S_MIN;
            end
            S_MIN: begin
                chunk   = CW'(min_x);
                chunk_n = CNT_W'(VALUE_WIDTH);
                n_step  = S_MAX;
            end
            S_MAX: begin
                chunk   = CW'(max_x);
                chunk_n = CNT_W'(VALUE_WIDTH);
                n_step  = S_CNT;
            end
            S_CNT: begin
                chunk   = CW'(count_x);
                chunk_n = CNT_W'(VALUE_WIDTH);
                fin     = !data_byte;
                n_step  = S_DATA;
            end
            S_DATA: begin
                chunk   = CW'(i_q_offset) << pad;
                chunk_n = CNT_W'(i_q_ctl.nbits) + CNT_W'(pad);
                fin     = 1'b1;
                n_step  = S_MAGIC;
            end
            default: begin
                n_step = S_MAGIC;
            end
        endcase
    end

    assign o_q_pop = load && (step_cur == S_DATA);
    assign acc_sh  = emit ? (r_acc << 8) : r_acc;
    assign shamt   = CNT_W'(AW) - cnt_after - chunk_n;

    always_comb begin
        n_acc   = acc_sh;
        n_cnt   = cnt_after;
        n_drain = r_drain;
        if (load) begin
            // place the field right below the bits already held
            n_acc   = acc_sh | (AW'(chunk) << shamt);
            n_cnt   = cnt_after + chunk_n;
            n_drain = fin && (n_cnt >= CNT_W'(8));
        end else if (emit && cnt_after < CNT_W'(8)) begin
            n_drain = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_step      <= S_MAGIC;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_drain <= n_drain;
            if (load) begin
                r_step <= n_step;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= r_acc[AW-1 -: 8];
            r_end  <= end_flag;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_out   = r_byte;
    assign o_end_of_run = r_end;

endmodule

// File: rtl/offset_bit_packer_core.sv
// Offset bit packer: signed samples in, packed byte stream out.
// Channels: input beat (i_value, i_last), output beat (o_byte_out,
// o_end_of_run), config write port (i_cfg_index, i_cfg_data).
// The first sample of a run sends "BIN!", min, max and count (each
// VALUE_WIDTH bits, MSB first), then every sample sends value - min in a
// field as wide as the bit length of max - min. A last sample pads the
// final byte with zeros and the next sample opens a new run.
// Output bytes leave one per cycle from an output register while the
// receiver is ready; a sample with a 32-bit field and no header makes 4 bytes.
// A header sample adds 4 + 3*VALUE_WIDTH/8 bytes. The first byte of a
// sample passes through the queue, the bit accumulator and the output register.
// A two-entry queue keeps accepting samples while the receiver stalls;
// o_in_ready drops only when the queue is full. Reset clears the queue, the
// bit accumulator and the run state, and sets min = max = 0, count = 1.
// Write config only while no sample is in flight.
module offset_bit_packer_core
    import obp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_value,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_byte_out,
    output logic                  o_end_of_run,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int Q_W = $bits(t_item_ctl) + VALUE_WIDTH;

    t_cfg                   r_cfg;
    logic                   q_push, q_full, q_pop, q_valid;
    t_item_ctl              f_ctl, b_ctl;
    logic [VALUE_WIDTH-1:0] f_offset, b_offset;
    logic [Q_W-1:0]         q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_value   <= '0;
            r_cfg.max_value   <= '0;
            r_cfg.value_count <= CFG_DATA_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN:   r_cfg.min_value   <= i_cfg_data;
                CFG_MAX:   r_cfg.max_value   <= i_cfg_data;
                CFG_COUNT: r_cfg.value_count <= i_cfg_data;
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    obp_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_value    (i_value),
        .i_last     (i_last),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_ctl    (f_ctl),
        .o_q_offset (f_offset)
    );

    obp_fifo #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata ({f_ctl, f_offset}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    assign b_ctl    = q_rdata[Q_W-1 -: $bits(t_item_ctl)];
    assign b_offset = q_rdata[VALUE_WIDTH-1:0];

    obp_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_ctl      (b_ctl),
        .i_q_offset   (b_offset),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_byte_out   (o_byte_out),
        .o_end_of_run (o_end_of_run)
    );

endmodule

// File: rtl/obp_checker.sv
// Port-level checks for offset_bit_packer_core, bound to the top level.
// Looks only at the handshake and output ports; no package dependencies.
module obp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_byte_out,
    input logic       o_end_of_run
);

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_byte_out) && $stable(o_end_of_run))
        else $error("stalled output beat changed");

    // reset drops any pending output beat
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // reset empties the queue, so input is taken right away
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind offset_bit_packer_core obp_checker u_obp_checker (.*);
